### rtl/sync_length_deframer_defines.svh
// ---------------------------------------------------------------------------
// Assertion macros for the sync length deframer
// Concurrent checks on clk_i, with or without the active-low reset guard.
// ---------------------------------------------------------------------------
`ifndef SYNC_LENGTH_DEFRAMER_DEFINES_SVH
`define SYNC_LENGTH_DEFRAMER_DEFINES_SVH

`ifndef ASSERT_OFF
// checked on clk_i, idle while rst_ni is low
`define SLD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
// checked on clk_i at every edge, reset included
`define SLD_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);
`else
`define SLD_ASSERT(lbl, prop, msg)
`define SLD_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

### rtl/sld_pkg.sv
// ---------------------------------------------------------------------------
// sld_pkg
// Shared types and codes of the sync length deframer.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package sld_pkg;

  localparam int unsigned CfgIdxW = 1;

  localparam logic [CfgIdxW-1:0] CFG_SYNC_WORD = 1'd0;
  localparam logic [CfgIdxW-1:0] CFG_LIMIT     = 1'd1;

  localparam logic [31:0] SYNC_WORD_RST = 32'h4141_4141;  // "AAAA"
  localparam logic [15:0] LIMIT_RST     = 16'd10000;

  // input op codes
  localparam logic [1:0] OP_RX_BYTE   = 2'd0;
  localparam logic [1:0] OP_WR_DONE   = 2'd1;
  localparam logic [1:0] OP_PEER_CLOSE = 2'd2;

  // parse phase codes
  localparam logic [1:0] PH_HUNT    = 2'd0;
  localparam logic [1:0] PH_LENGTH  = 2'd1;
  localparam logic [1:0] PH_PAYLOAD = 2'd2;

  typedef struct packed {
    logic [31:0] sync_word;
    logic [15:0] limit;
  } cfg_t;

  typedef struct packed {
    logic        payload_valid;
    logic [7:0]  payload_byte;
    logic        frame_end;
    logic        frame_dropped;
    logic        link_closed;
    logic [15:0] outstanding_count;
  } res_t;

endpackage

### rtl/sld_cfg_regs.sv
// ---------------------------------------------------------------------------
// sld_cfg_regs
// Configuration registers: sync word and outstanding limit.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module sld_cfg_regs import sld_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               wr_en_i,
  input  logic [CfgIdxW-1:0] wr_idx_i,
  input  logic [31:0]        wr_data_i,
  output cfg_t               cfg_o
);

  cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en_i) begin
      unique case (wr_idx_i)
        CFG_SYNC_WORD: cfg_d.sync_word = wr_data_i;
        CFG_LIMIT:     cfg_d.limit     = wr_data_i[15:0];
        default:       cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.sync_word <= SYNC_WORD_RST;
      cfg_q.limit     <= LIMIT_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

### rtl/sld_parser.sv
// ---------------------------------------------------------------------------
// sld_parser
// Parse state and the result of one item; state moves on adv_i.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "sync_length_deframer_defines.svh"

module sld_parser import sld_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  cfg_t       cfg_i,
  input  logic       adv_i,
  input  logic [1:0] op_i,
  input  logic [7:0] byte_i,
  output res_t       res_o
);

  logic [23:0] win_q, win_d;
  logic [1:0]  fill_q, fill_d;
  logic [1:0]  phase_q, phase_d;
  logic [1:0]  lidx_q, lidx_d;
  logic [31:0] flen_q, flen_d;
  logic [31:0] rem_q, rem_d;
  logic [15:0] cnt_q, cnt_d;
  logic        closed_q, closed_d;

  logic [31:0] flen_or;
  logic [15:0] cnt_inc;
  logic        limit_hit;
  res_t        res;

  always_comb begin
    case (lidx_q)
      2'd0:    flen_or = flen_q | {24'd0, byte_i};
      2'd1:    flen_or = flen_q | {16'd0, byte_i, 8'd0};
      2'd2:    flen_or = flen_q | {8'd0, byte_i, 16'd0};
      default: flen_or = flen_q | {byte_i, 24'd0};
    endcase
  end

  // frame completion: saturating count, dropped when it reaches the limit
  assign cnt_inc   = (cnt_q != 16'hFFFF) ? cnt_q + 16'd1 : cnt_q;
  assign limit_hit = (cnt_inc >= cfg_i.limit);

  always_comb begin
    win_d    = win_q;
    fill_d   = fill_q;
    phase_d  = phase_q;
    lidx_d   = lidx_q;
    flen_d   = flen_q;
    rem_d    = rem_q;
    cnt_d    = cnt_q;
    closed_d = closed_q;
    res      = '0;

    unique case (op_i)
      OP_RX_BYTE: begin
        if (!closed_q) begin
          unique case (phase_q)
            PH_LENGTH: begin
              flen_d = flen_or;
              if (lidx_q == 2'd3) begin
                lidx_d = 2'd0;
                if (flen_or == 32'd0) begin
                  res.frame_end     = 1'b1;
                  res.frame_dropped = limit_hit;
                  cnt_d             = cnt_inc;
                  closed_d          = limit_hit;
                  phase_d           = PH_HUNT;
                  win_d             = '0;
                  fill_d            = '0;
                end else begin
                  rem_d   = flen_or;
                  phase_d = PH_PAYLOAD;
                end
              end else begin
                lidx_d = lidx_q + 2'd1;
              end
            end
            PH_PAYLOAD: begin
              res.payload_valid = 1'b1;
              res.payload_byte  = byte_i;
              rem_d             = rem_q - 32'd1;
              if (rem_q == 32'd1) begin
                res.frame_end     = 1'b1;
                res.frame_dropped = limit_hit;
                cnt_d             = cnt_inc;
                closed_d          = limit_hit;
                phase_d           = PH_HUNT;
                win_d             = '0;
                fill_d            = '0;
              end
            end
            default: begin
              // sliding four-byte match, newest byte on top
              if (fill_q == 2'd3 && {byte_i, win_q} == cfg_i.sync_word) begin
                win_d   = '0;
                fill_d  = '0;
                phase_d = PH_LENGTH;
                lidx_d  = 2'd0;
                flen_d  = '0;
              end else begin
                win_d = {byte_i, win_q[23:8]};
                if (fill_q != 2'd3) begin
                  fill_d = fill_q + 2'd1;
                end
              end
            end
          endcase
        end
      end
      OP_WR_DONE: begin
        if (cnt_q != 16'd0) begin
          cnt_d = cnt_q - 16'd1;
        end
      end
      OP_PEER_CLOSE: closed_d = 1'b1;
      default: ;
    endcase

    res.link_closed       = closed_d;
    res.outstanding_count = cnt_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q    <= '0;
      fill_q   <= '0;
      phase_q  <= PH_HUNT;
      lidx_q   <= '0;
      flen_q   <= '0;
      rem_q    <= '0;
      cnt_q    <= '0;
      closed_q <= 1'b0;
    end else if (adv_i) begin
      win_q    <= win_d;
      fill_q   <= fill_d;
      phase_q  <= phase_d;
      lidx_q   <= lidx_d;
      flen_q   <= flen_d;
      rem_q    <= rem_d;
      cnt_q    <= cnt_d;
      closed_q <= closed_d;
    end
  end

  assign res_o = res;

  `SLD_ASSERT(a_hold_when_idle, !adv_i |=> $stable(cnt_q) && $stable(phase_q), "state moved without an item")
  `SLD_ASSERT(a_closed_sticks, closed_q |=> closed_q, "link reopened")
  `SLD_ASSERT(a_payload_phase, adv_i && res.payload_valid |-> phase_q == PH_PAYLOAD, "payload outside payload phase")
  `SLD_ASSERT(a_drop_closes, adv_i && res.frame_dropped |-> res.link_closed && res.frame_end, "drop without close")

endmodule

### rtl/sync_length_deframer.sv
// ---------------------------------------------------------------------------
// sync_length_deframer
// Sync-word hunt, little-endian length and payload pass-through with
// outstanding-frame accounting.
// ---------------------------------------------------------------------------
//  channel  | dir | handshake                  | content
//  s_axis   | in  | s_axis_tvalid/tready       | tdata data_byte, tuser op
//  m_axis   | out | m_axis_tvalid/tready       | tdata payload/status, tuser
//           |     |                            | payload_valid, tlast frame_end
//  cfg      | in  | cfg_valid_i/cfg_ready_o    | cfg_index_i, cfg_data_i
//
//  One result item per input item, one item per cycle sustained while
//  m_axis_tready stays high: an input register feeds the parse logic,
//  whose result lands in the output register, which drives m_axis_tvalid.
//  An accepted item passes the input register, then the output register.
//  A stalled output still lets the input register fill; m_axis_tready is
//  looked at combinationally to keep the flow going at full rate.
//  Reset clears both handshake stages and the parse state; configuration
//  returns to "AAAA" and a limit of 10000. cfg_ready_o is always high.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module sync_length_deframer import sld_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  // config write channel
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic [31:0]        cfg_data_i,
  // input items
  input  logic               s_axis_tvalid,
  output logic               s_axis_tready,
  input  logic [7:0]         s_axis_tdata,   // [7:0] data_byte
  input  logic [1:0]         s_axis_tuser,   // [1:0] op
  // result items
  output logic               m_axis_tvalid,
  input  logic               m_axis_tready,
  output logic [31:0]        m_axis_tdata,   // [7:0] payload_byte, [8] frame_dropped,
                                             // [9] link_closed, [25:10] outstanding_count,
                                             // [31:26] zero
  output logic               m_axis_tuser,   // [0] payload_valid
  output logic               m_axis_tlast    // frame_end
);

  cfg_t       cfg;
  res_t       res;

  logic       in_valid_q;
  logic [1:0] in_op_q;
  logic [7:0] in_byte_q;
  logic       out_valid_q;
  res_t       out_res_q;
  logic       adv;

  assign cfg_ready_o = 1'b1;

  sld_cfg_regs u_cfg (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_en_i   (cfg_valid_i),
    .wr_idx_i  (cfg_index_i),
    .wr_data_i (cfg_data_i),
    .cfg_o     (cfg)
  );

  // item moves from the input register into the output register
  assign adv           = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_op_q   <= s_axis_tuser;
      in_byte_q <= s_axis_tdata;
    end
  end

  sld_parser u_parser (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg),
    .adv_i  (adv),
    .op_i   (in_op_q),
    .byte_i (in_byte_q),
    .res_o  (res)
  );

  // output register: loads on adv, empties when taken with nothing behind
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_res_q <= res;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = out_res_q.payload_valid;
  assign m_axis_tlast  = out_res_q.frame_end;
  assign m_axis_tdata  = {6'd0, out_res_q.outstanding_count, out_res_q.link_closed,
                          out_res_q.frame_dropped, out_res_q.payload_byte};

endmodule
